// ===== rtl/dhkt_pkg.sv =====
// shared constants, codes and control types for the double hash key table
package dhkt_pkg;

    // storage geometry
    localparam int LOG2_DEPTH = 8;
    localparam int DEPTH      = 1 << LOG2_DEPTH;
    localparam int IDX_W      = LOG2_DEPTH;
    localparam int KEY_BYTES  = 8;
    localparam int KEY_W      = 64;
    localparam int LEN_W      = 4;
    localparam int DATA_W     = 32;
    localparam int HASH_W     = 16;
    localparam int CFG_W      = 4;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    // register index of table_size_log2, taken from paddr bit 2
    localparam logic REG_TABLE_SIZE = 1'b0;

    // request opcodes
    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_ZERO = 2'd3
    } t_status;

    // one table row
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } t_slot;

    // controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    hash;
        logic    read;
        logic    advance;
        logic    write;
        logic    clear;
        logic    emit;
        t_status res_code;
        logic    res_data;
        logic    res_slot;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       data_zero;
        logic       hit;
        logic       occupied;
        logic       wrap;
    } t_dp_sts;

endpackage

// ===== rtl/dhkt_if.sv =====
// request and result channel interfaces of the key table
interface dhkt_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   opcode;
    logic [dhkt_pkg::KEY_W-1:0]   key_value;
    logic [dhkt_pkg::LEN_W-1:0]   key_len;
    logic [dhkt_pkg::DATA_W-1:0]  data_value;

    modport source (output valid, output opcode, output key_value, output key_len,
                    output data_value, input ready);
    modport sink   (input valid, input opcode, input key_value, input key_len,
                    input data_value, output ready);
endinterface

interface dhkt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [dhkt_pkg::DATA_W-1:0]  data_out;
    logic [dhkt_pkg::IDX_W-1:0]   slot_index;

    modport source (output valid, output status, output data_out, output slot_index,
                    input ready);
    modport sink   (input valid, input status, input data_out, input slot_index,
                    output ready);
endinterface

// ===== rtl/dhkt_datapath.sv =====
// key table datapath: request registers, hash, probe index, slot memory, result register
module dhkt_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dhkt_pkg::t_dp_cmd            i_cmd,
    output dhkt_pkg::t_dp_sts            o_sts,
    input  logic [1:0]                   i_opcode,
    input  logic [dhkt_pkg::KEY_W-1:0]   i_key_value,
    input  logic [dhkt_pkg::LEN_W-1:0]   i_key_len,
    input  logic [dhkt_pkg::DATA_W-1:0]  i_data_value,
    input  logic [dhkt_pkg::CFG_W-1:0]   i_table_size_log2,
    output logic [1:0]                   o_status,
    output logic [dhkt_pkg::DATA_W-1:0]  o_data_out,
    output logic [dhkt_pkg::IDX_W-1:0]   o_slot_index
);

    // byte hash: rotate left by 4, xor sign-extended byte, then fold
    function automatic logic [dhkt_pkg::HASH_W-1:0] key_hash(
        input logic [dhkt_pkg::KEY_W-1:0] key,
        input logic [dhkt_pkg::LEN_W-1:0] len
    );
        logic [dhkt_pkg::HASH_W-1:0] h;
        logic [dhkt_pkg::HASH_W-1:0] b;
        h = dhkt_pkg::HASH_W'(len);
        for (int i = 0; i < dhkt_pkg::KEY_BYTES; i++) begin
            if (dhkt_pkg::LEN_W'(i) < len) begin
                b = {{8{key[8*i+7]}}, key[8*i +: 8]};
                h = {h[11:0], h[15:12]} ^ b;
            end
        end
        return h ^ (h >> 6) ^ (h >> 13);
    endfunction

    logic [1:0]                    r_op;
    logic [dhkt_pkg::KEY_W-1:0]    r_key;
    logic [dhkt_pkg::LEN_W-1:0]    r_len;
    logic [dhkt_pkg::DATA_W-1:0]   r_data;
    logic [dhkt_pkg::CFG_W-1:0]    r_lg;
    logic [dhkt_pkg::IDX_W-1:0]    r_first;
    logic [dhkt_pkg::IDX_W-1:0]    r_idx;
    logic [dhkt_pkg::IDX_W-1:0]    r_step;
    logic [dhkt_pkg::DEPTH-1:0]    r_valid;
    logic                          r_rd_valid;
    dhkt_pkg::t_slot               r_rd_slot;
    dhkt_pkg::t_slot               r_mem [dhkt_pkg::DEPTH];
    logic [1:0]                    r_status;
    logic [dhkt_pkg::DATA_W-1:0]   r_data_out;
    logic [dhkt_pkg::IDX_W-1:0]    r_slot_index;

    logic [dhkt_pkg::LEN_W-1:0]    len_c;
    logic [dhkt_pkg::KEY_W-1:0]    key_c;
    logic [dhkt_pkg::CFG_W-1:0]    lg_c;
    logic [dhkt_pkg::IDX_W:0]      one_sh;
    logic [dhkt_pkg::IDX_W-1:0]    mask;
    logic [dhkt_pkg::HASH_W-1:0]   hash;
    logic [2*dhkt_pkg::HASH_W-1:0] rot_w;
    logic [dhkt_pkg::IDX_W-1:0]    step;
    logic [dhkt_pkg::IDX_W-1:0]    next_idx;

    // clamp length, drop unused key bytes, clamp table size
    always_comb begin
        len_c = (i_key_len > dhkt_pkg::LEN_W'(dhkt_pkg::KEY_BYTES))
              ? dhkt_pkg::LEN_W'(dhkt_pkg::KEY_BYTES) : i_key_len;
        for (int b = 0; b < dhkt_pkg::KEY_BYTES; b++) begin
            key_c[8*b +: 8] = (dhkt_pkg::LEN_W'(b) < len_c) ? i_key_value[8*b +: 8] : 8'd0;
        end
        if (i_table_size_log2 == '0) begin
            lg_c = dhkt_pkg::CFG_W'(1);
        end else if (i_table_size_log2 > dhkt_pkg::CFG_W'(dhkt_pkg::LOG2_DEPTH)) begin
            lg_c = dhkt_pkg::CFG_W'(dhkt_pkg::LOG2_DEPTH);
        end else begin
            lg_c = i_table_size_log2;
        end
    end

    // slot mask, hash, double hash step and next probe
    always_comb begin
        one_sh   = (dhkt_pkg::IDX_W+1)'(1) << r_lg;
        mask     = dhkt_pkg::IDX_W'(one_sh - (dhkt_pkg::IDX_W+1)'(1));
        hash     = key_hash(r_key, r_len);
        rot_w    = {hash, hash} >> r_lg;
        step     = (rot_w[dhkt_pkg::IDX_W-1:0] & mask) | dhkt_pkg::IDX_W'(1);
        next_idx = (r_idx + r_step) & mask;
    end

    // request registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_key  <= key_c;
            r_len  <= len_c;
            r_data <= i_data_value;
            r_lg   <= lg_c;
        end
    end

    // probe index registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.hash) begin
            r_first <= hash[dhkt_pkg::IDX_W-1:0] & mask;
            r_idx   <= hash[dhkt_pkg::IDX_W-1:0] & mask;
            r_step  <= step;
        end else if (i_cmd.advance) begin
            r_idx   <= next_idx;
        end
    end

    // slot occupancy flags, cleared together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_valid <= '0;
            end else if (i_cmd.write) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (i_cmd.read) begin
                r_rd_valid <= r_valid[r_idx];
            end
        end
    end

    // slot memory, one write or one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_mem[r_idx] <= '{key: r_key, len: r_len, data: r_data};
        end
        if (i_cmd.read) begin
            r_rd_slot <= r_mem[r_idx];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status     <= i_cmd.res_code;
            r_data_out   <= i_cmd.res_data ? r_rd_slot.data : '0;
            r_slot_index <= i_cmd.res_slot ? r_idx : '0;
        end
    end

    // status toward the controller
    always_comb begin
        o_sts.op        = r_op;
        o_sts.data_zero = (r_data == '0);
        o_sts.occupied  = r_rd_valid;
        o_sts.hit       = !r_rd_valid || (r_rd_slot.len == r_len && r_rd_slot.key == r_key);
        o_sts.wrap      = (next_idx == r_first);
    end

    assign o_status     = r_status;
    assign o_data_out   = r_data_out;
    assign o_slot_index = r_slot_index;

endmodule

// ===== rtl/dhkt_ctrl.sv =====
// key table controller: request sequencing, probe loop and result handshake
module dhkt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output dhkt_pkg::t_dp_cmd  o_cmd,
    input  dhkt_pkg::t_dp_sts  i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_CHECK,
        S_RESULT
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic               r_out_valid;
    dhkt_pkg::t_status  r_res_code;
    dhkt_pkg::t_status  n_res_code;
    logic               r_res_data;
    logic               n_res_data;
    logic               r_res_slot;
    logic               n_res_slot;
    logic               accept;
    logic               out_free;

    assign accept   = i_req_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_rsp_ready;

    // next state, commands and result selection
    always_comb begin
        n_state    = r_state;
        n_res_code = r_res_code;
        n_res_data = r_res_data;
        n_res_slot = r_res_slot;
        o_cmd      = '0;
        o_cmd.res_code = r_res_code;
        o_cmd.res_data = r_res_data;
        o_cmd.res_slot = r_res_slot;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_code = dhkt_pkg::ST_MISS;
                n_res_data = 1'b0;
                n_res_slot = 1'b0;
                n_state    = S_RESULT;
                if (i_sts.op == dhkt_pkg::OP_CLEAR) begin
                    o_cmd.clear = 1'b1;
                    n_res_code  = dhkt_pkg::ST_OK;
                end else if (i_sts.op == dhkt_pkg::OP_INSERT && i_sts.data_zero) begin
                    n_res_code  = dhkt_pkg::ST_ZERO;
                end else if (i_sts.op == dhkt_pkg::OP_FIND
                             || i_sts.op == dhkt_pkg::OP_INSERT) begin
                    o_cmd.hash  = 1'b1;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.hit) begin
                    n_state = S_RESULT;
                    if (i_sts.op == dhkt_pkg::OP_INSERT) begin
                        o_cmd.write = 1'b1;
                        n_res_code  = dhkt_pkg::ST_OK;
                        n_res_slot  = 1'b1;
                    end else if (i_sts.occupied) begin
                        n_res_code  = dhkt_pkg::ST_OK;
                        n_res_data  = 1'b1;
                        n_res_slot  = 1'b1;
                    end
                end else if (i_sts.wrap) begin
                    n_state = S_RESULT;
                    if (i_sts.op == dhkt_pkg::OP_INSERT) begin
                        n_res_code = dhkt_pkg::ST_FULL;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_res_code  <= dhkt_pkg::ST_MISS;
            r_res_data  <= 1'b0;
            r_res_slot  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_res_code <= n_res_code;
            r_res_data <= n_res_data;
            r_res_slot <= n_res_slot;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

    // a result register load never overwrites an untaken result
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> out_free)
        else $error("result overwritten before taken");

    // table writes only come from an insert that hit
    a_write_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write |-> (i_sts.op == dhkt_pkg::OP_INSERT && i_sts.hit))
        else $error("slot write outside a matching insert");

    // probing moves on only after a miss that has not wrapped
    a_advance_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.advance |-> (!i_sts.hit && !i_sts.wrap))
        else $error("probe advanced past a hit or wrap");

    // a new result appears only out of the result state
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_RESULT)
        else $error("result valid raised outside result state");

endmodule

// ===== rtl/double_hash_key_table.sv =====
// top level of the double hashing key table with its configuration register
//
//  channel   direction  handshake        payload
//  i_req     in         valid/ready      opcode, key_value, key_len, data_value
//  o_rsp     out        valid/ready      status, data_out, slot_index
//  apb       in         psel/penable     table_size_log2 at byte address 0
//
//  a request steps through accept, decode, then one memory read and one compare per
//  probe, then the result register load; clear and refused requests skip the probes
//  and go from decode to the result load; a clear resets all occupancy flags together
//  a synchronous reset empties the table at once (no clearing pass)
//  one request at a time; a new request is taken while the last result waits
//  a stalled result holds the controller in its result state until taken
module double_hash_key_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dhkt_req_if.sink                      i_req,
    dhkt_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dhkt_pkg::APB_AW-1:0]   paddr,
    input  logic [dhkt_pkg::APB_DW-1:0]   pwdata,
    output logic [dhkt_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    logic [dhkt_pkg::CFG_W-1:0] r_table_size_log2;
    dhkt_pkg::t_dp_cmd          cmd;
    dhkt_pkg::t_dp_sts          sts;
    logic                       reg_sel;

    assign reg_sel = (paddr[2] == dhkt_pkg::REG_TABLE_SIZE);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size_log2 <= dhkt_pkg::CFG_W'(dhkt_pkg::LOG2_DEPTH);
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_table_size_log2 <= pwdata[dhkt_pkg::CFG_W-1:0];
        end
    end

    // register readback
    assign prdata = reg_sel ? dhkt_pkg::APB_DW'(r_table_size_log2) : '0;
    assign pready = 1'b1;

    dhkt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    dhkt_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_opcode          (i_req.opcode),
        .i_key_value       (i_req.key_value),
        .i_key_len         (i_req.key_len),
        .i_data_value      (i_req.data_value),
        .i_table_size_log2 (r_table_size_log2),
        .o_status          (o_rsp.status),
        .o_data_out        (o_rsp.data_out),
        .o_slot_index      (o_rsp.slot_index)
    );

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the double hash key table: directed and random requests, scoreboard
module testbench;

    localparam logic [1:0]                  OP_UNUSED        = 2'd3;
    localparam logic [dhkt_pkg::APB_AW-1:0] SIZE_REG_ADDR    = {dhkt_pkg::REG_TABLE_SIZE, 2'b00};
    localparam int                          POOL_SIZE        = 10;
    localparam int                          N_PHASES         = 8;
    localparam int                          RANDOM_PER_PHASE = 80;
    localparam int                          LONG_HOLD        = 300;
    localparam int                          WATCHDOG_LIMIT   = 5000;
    localparam logic [dhkt_pkg::CFG_W-1:0]  PHASE_SIZES [N_PHASES] = '{
        4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd2, 4'd5, 4'd8
    };

    // one result of the table
    typedef struct packed {
        dhkt_pkg::t_status           status;
        logic [dhkt_pkg::DATA_W-1:0] data_out;
        logic [dhkt_pkg::IDX_W-1:0]  slot_index;
    } t_table_result;

    // shadow copy of the table and the queue of results still owed
    class key_table_scoreboard;
        logic [dhkt_pkg::DATA_W-1:0] slot_data [dhkt_pkg::DEPTH];
        logic [dhkt_pkg::KEY_W-1:0]  slot_key  [dhkt_pkg::DEPTH];
        logic [dhkt_pkg::LEN_W-1:0]  slot_len  [dhkt_pkg::DEPTH];
        logic [dhkt_pkg::CFG_W-1:0]  size_reg;
        t_table_result               expected_q [$];
        int                          errors;
        int                          checked;
        int                          status_count [4];

        function new();
            size_reg = 4'd8;
            errors   = 0;
            checked  = 0;
            foreach (slot_data[i]) slot_data[i] = '0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        // mask of the valid key bytes for a clamped length
        static function logic [dhkt_pkg::KEY_W-1:0] byte_mask(int len);
            if (len >= dhkt_pkg::KEY_BYTES) return '1;
            return (64'd1 << (8 * len)) - 64'd1;
        endfunction

        // rotate-xor over sign-extended bytes, then fold
        static function logic [dhkt_pkg::HASH_W-1:0] key_hash(
            logic [dhkt_pkg::KEY_W-1:0] key, int len);
            logic [dhkt_pkg::HASH_W-1:0] h;
            logic [dhkt_pkg::HASH_W-1:0] b;
            h = dhkt_pkg::HASH_W'(len);
            for (int i = 0; i < len; i++) begin
                b = {{8{key[8*i+7]}}, key[8*i +: 8]};
                h = {h[11:0], h[15:12]} ^ b;
            end
            return h ^ (h >> 6) ^ (h >> 13);
        endfunction

        // empty slot or same key
        function bit slot_usable(int idx, logic [dhkt_pkg::KEY_W-1:0] key, int len);
            if (slot_data[idx] == '0) return 1'b1;
            return slot_len[idx] == dhkt_pkg::LEN_W'(len) && slot_key[idx] == key;
        endfunction

        // double hashing probe sequence, stops when back at the first slot
        function bit find_slot(logic [dhkt_pkg::KEY_W-1:0] key, int len, int lg,
                               output int where);
            logic [dhkt_pkg::HASH_W-1:0] h;
            logic [31:0]                 twice;
            int                          mask;
            int                          start;
            int                          idx;
            int                          stride;
            h     = key_hash(key, len);
            mask  = (1 << lg) - 1;
            start = int'(h) & mask;
            idx   = start;
            where = 0;
            if (slot_usable(idx, key, len)) begin
                where = idx;
                return 1'b1;
            end
            twice  = {h, h};
            stride = (int'(twice >> lg) & mask) | 1;
            do begin
                idx = (idx + stride) & mask;
                if (slot_usable(idx, key, len)) begin
                    where = idx;
                    return 1'b1;
                end
            end while (idx != start);
            return 1'b0;
        endfunction

        // predict the result of an accepted request and update the shadow table
        function void note_request(logic [1:0] op, logic [dhkt_pkg::KEY_W-1:0] key_in,
                                   logic [dhkt_pkg::LEN_W-1:0] len_in,
                                   logic [dhkt_pkg::DATA_W-1:0] data);
            t_table_result              r;
            int                         lg;
            int                         len;
            int                         where;
            logic [dhkt_pkg::KEY_W-1:0] key;
            lg  = (size_reg < 1) ? 1 :
                  (size_reg > dhkt_pkg::LOG2_DEPTH) ? dhkt_pkg::LOG2_DEPTH : int'(size_reg);
            len = (len_in > dhkt_pkg::KEY_BYTES) ? dhkt_pkg::KEY_BYTES : int'(len_in);
            key = key_in & byte_mask(len);
            where = 0;
            r.status     = dhkt_pkg::ST_MISS;
            r.data_out   = '0;
            r.slot_index = '0;
            case (op)
                dhkt_pkg::OP_FIND: begin
                    if (find_slot(key, len, lg, where) && slot_data[where] != '0) begin
                        r.status     = dhkt_pkg::ST_OK;
                        r.data_out   = slot_data[where];
                        r.slot_index = dhkt_pkg::IDX_W'(where);
                    end
                end
                dhkt_pkg::OP_INSERT: begin
                    if (data == '0) begin
                        r.status = dhkt_pkg::ST_ZERO;
                    end else if (!find_slot(key, len, lg, where)) begin
                        r.status = dhkt_pkg::ST_FULL;
                    end else begin
                        slot_key[where]  = key;
                        slot_len[where]  = dhkt_pkg::LEN_W'(len);
                        slot_data[where] = data;
                        r.status         = dhkt_pkg::ST_OK;
                        r.slot_index     = dhkt_pkg::IDX_W'(where);
                    end
                end
                dhkt_pkg::OP_CLEAR: begin
                    foreach (slot_data[i]) slot_data[i] = '0;
                    r.status = dhkt_pkg::ST_OK;
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        // compare a result with the oldest prediction
        function void check_result(logic [1:0] status, logic [dhkt_pkg::DATA_W-1:0] data_out,
                                   logic [dhkt_pkg::IDX_W-1:0] slot_index);
            t_table_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no request: status %0d data %h slot %0d",
                         $time, status, data_out, slot_index);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            status_count[e.status]++;
            if (status !== e.status) begin
                $display("%0t: status mismatch, expected %0d, got %0d", $time, e.status, status);
                errors++;
            end
            if (data_out !== e.data_out) begin
                $display("%0t: data_out mismatch, expected %h, got %h",
                         $time, e.data_out, data_out);
                errors++;
            end
            if (slot_index !== e.slot_index) begin
                $display("%0t: slot_index mismatch, expected %0d, got %0d",
                         $time, e.slot_index, slot_index);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [dhkt_pkg::APB_AW-1:0]  paddr;
    logic [dhkt_pkg::APB_DW-1:0]  pwdata;
    logic [dhkt_pkg::APB_DW-1:0]  prdata;
    logic                         pready;

    dhkt_req_if req_ch ();
    dhkt_rsp_if rsp_ch ();

    key_table_scoreboard        sb;
    bit                         calm;
    bit                         hold_long;
    int                         quiet_cycles;
    logic [dhkt_pkg::KEY_W-1:0] pool_key [POOL_SIZE];
    int                         pool_len [POOL_SIZE];

    double_hash_key_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // monitors for accepted requests and results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.opcode, req_ch.key_value, req_ch.key_len,
                                req_ch.data_value);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.status, rsp_ch.data_out, rsp_ch.slot_index);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // result receiver: random stalls, one long hold-off on request
    initial begin
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_long) begin
                hold_long = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [dhkt_pkg::KEY_W-1:0] random_key();
        return {$urandom(), $urandom()};
    endfunction

    // offer one request, wait for it to be taken, then maybe idle
    task automatic send_request(logic [1:0] op, logic [dhkt_pkg::KEY_W-1:0] key,
                                logic [dhkt_pkg::LEN_W-1:0] len,
                                logic [dhkt_pkg::DATA_W-1:0] data);
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.key_value  <= key;
        req_ch.key_len    <= len;
        req_ch.data_value <= data;
        do @(posedge i_clk); while (!req_ch.ready);
        if (!calm && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // reuse a known key with fresh junk in the unused bytes and, for a full-length key, in the length
    task automatic send_pool_key(logic [1:0] op, int k, logic [dhkt_pkg::DATA_W-1:0] data);
        logic [dhkt_pkg::KEY_W-1:0] m;
        logic [dhkt_pkg::LEN_W-1:0] len_raw;
        m = key_table_scoreboard::byte_mask(pool_len[k]);
        len_raw = (pool_len[k] == dhkt_pkg::KEY_BYTES) ?
                  dhkt_pkg::LEN_W'($urandom_range(8, 15)) : dhkt_pkg::LEN_W'(pool_len[k]);
        send_request(op, (pool_key[k] & m) | (random_key() & ~m), len_raw, data);
    endtask

    // stop offering and wait until every result is back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // write the size register, then read it back
    task automatic write_table_size(logic [dhkt_pkg::CFG_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIZE_REG_ADDR;
        pwdata  <= {28'($urandom()), v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.size_reg = v;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== dhkt_pkg::APB_DW'(v)) begin
            $display("%0t: table_size_log2 readback mismatch, expected %h, got %h",
                     $time, dhkt_pkg::APB_DW'(v), prdata);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // directed cases on the full-size table
    task automatic run_directed();
        // find on an empty table
        send_request(dhkt_pkg::OP_FIND, 64'h0123_4567_89AB_CDEF, 4'd8, '0);
        // zero-length key, any key bits ignored
        send_request(dhkt_pkg::OP_INSERT, random_key(), 4'd0, 32'h0000_0001);
        send_request(dhkt_pkg::OP_FIND, random_key(), 4'd0, '0);
        // zero data refused
        send_request(dhkt_pkg::OP_INSERT, 64'h1122, 4'd2, '0);
        // all-ones key and data, then a find with length above eight
        send_request(dhkt_pkg::OP_INSERT, '1, 4'd8, '1);
        send_request(dhkt_pkg::OP_FIND, '1, 4'd15, '0);
        // bytes with the sign bit set, then overwrite with junk above the length
        send_request(dhkt_pkg::OP_INSERT, 64'h0000_0000_0080_FF80, 4'd3, 32'h1234_5678);
        send_request(dhkt_pkg::OP_INSERT, 64'hDEAD_BEEF_AA80_FF80, 4'd3, 32'h8765_4321);
        send_request(dhkt_pkg::OP_FIND, 64'h0000_0000_0080_FF80, 4'd3, $urandom());
        // same bytes but another length do not match
        send_request(dhkt_pkg::OP_FIND, 64'h0000_0000_0080_FF80, 4'd4, '0);
        send_request(OP_UNUSED, random_key(), 4'd5, '1);
        send_request(dhkt_pkg::OP_CLEAR, random_key(), 4'd7, $urandom());
        send_request(dhkt_pkg::OP_FIND, '1, 4'd8, '0);
        send_request(dhkt_pkg::OP_INSERT, 64'h7F, 4'd1, 32'h8000_0000);
        send_request(dhkt_pkg::OP_INSERT, random_key(), 4'd9, 32'hA5A5_A5A5);
    endtask

    // two-slot table: fill it, overflow it, miss on it
    task automatic run_full_table();
        send_request(dhkt_pkg::OP_CLEAR, '0, 4'd0, '0);
        for (int i = 1; i <= 3; i++)
            send_request(dhkt_pkg::OP_INSERT, dhkt_pkg::KEY_W'(i), 4'd1, dhkt_pkg::DATA_W'(i));
        send_request(dhkt_pkg::OP_FIND, 64'h55, 4'd1, '0);
        send_request(dhkt_pkg::OP_FIND, 64'h1, 4'd1, '0);
    endtask

    // mostly known keys so finds hit and inserts overwrite or fill up
    task automatic run_random(int count);
        int pick;
        int k;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, POOL_SIZE - 1);
            if (pick < 38)
                send_pool_key(dhkt_pkg::OP_INSERT, k, $urandom());
            else if (pick < 70)
                send_pool_key(dhkt_pkg::OP_FIND, k, $urandom());
            else if (pick < 78)
                send_request(dhkt_pkg::OP_FIND, random_key(),
                             dhkt_pkg::LEN_W'($urandom_range(0, 15)), $urandom());
            else if (pick < 86)
                send_request(dhkt_pkg::OP_INSERT, random_key(),
                             dhkt_pkg::LEN_W'($urandom_range(0, 15)), $urandom());
            else if (pick < 91)
                send_pool_key(dhkt_pkg::OP_INSERT, k, '0);
            else if (pick < 95)
                send_request(OP_UNUSED, random_key(),
                             dhkt_pkg::LEN_W'($urandom_range(0, 15)), $urandom());
            else
                send_request(dhkt_pkg::OP_CLEAR, random_key(),
                             dhkt_pkg::LEN_W'($urandom_range(0, 15)), $urandom());
        end
    endtask

    // main sequence
    initial begin
        sb                = new();
        calm              = 1'b0;
        hold_long         = 1'b0;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_ch.valid      = 1'b0;
        req_ch.opcode     = dhkt_pkg::OP_FIND;
        req_ch.key_value  = '0;
        req_ch.key_len    = '0;
        req_ch.data_value = '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_key[i] = random_key();
            pool_len[i] = $urandom_range(0, dhkt_pkg::KEY_BYTES);
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            write_table_size(PHASE_SIZES[p]);
            if (p == 0) run_directed();
            if (p == 1) run_full_table();
            if (p == 2) hold_long = 1'b1;
            if (p == N_PHASES - 1) calm = 1'b1;
            run_random(RANDOM_PER_PHASE);
        end
        drain_results();

        $display("testbench: %0d results over %0d table sizes", sb.checked, N_PHASES);
        $display("testbench: %0d ok, %0d miss, %0d full, %0d refused",
                 sb.status_count[dhkt_pkg::ST_OK], sb.status_count[dhkt_pkg::ST_MISS],
                 sb.status_count[dhkt_pkg::ST_FULL], sb.status_count[dhkt_pkg::ST_ZERO]);
        if (sb.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
